@@ hw/rtl/swa_pkg.sv @@
// ----------------------------------------------------------------------------
// swa_pkg
// shared types and constants for the signed word alu
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int WORD_BITS = 23;
    localparam int CMD_BITS  = 5;
    localparam int CNT_BITS  = 5;
    localparam int IN_BITS   = CMD_BITS + 2 * WORD_BITS + CNT_BITS;
    localparam int IN_BYTES  = (IN_BITS + 7) / 8;
    localparam int OUT_BYTES = (WORD_BITS + 7) / 8;

    // divider unrolling: restoring steps per stage and number of stages
    localparam int DIV_STEPS  = 4;
    localparam int DIV_STAGES = (WORD_BITS + DIV_STEPS - 1) / DIV_STEPS;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CMD_BITS-1:0]  cmd_t;
    typedef logic [CNT_BITS-1:0]  cnt_t;

    localparam cmd_t CMD_ADD = 5'd0;
    localparam cmd_t CMD_SUB = 5'd1;
    localparam cmd_t CMD_MUL = 5'd2;
    localparam cmd_t CMD_DIV = 5'd3;
    localparam cmd_t CMD_REM = 5'd4;
    localparam cmd_t CMD_AND = 5'd5;
    localparam cmd_t CMD_OR  = 5'd6;
    localparam cmd_t CMD_XOR = 5'd7;
    localparam cmd_t CMD_NOT = 5'd8;
    localparam cmd_t CMD_SHL = 5'd9;
    localparam cmd_t CMD_SHR = 5'd10;
    localparam cmd_t CMD_EQ  = 5'd11;
    localparam cmd_t CMD_NE  = 5'd12;
    localparam cmd_t CMD_LT  = 5'd13;
    localparam cmd_t CMD_LE  = 5'd14;
    localparam cmd_t CMD_GT  = 5'd15;
    localparam cmd_t CMD_GE  = 5'd16;

    // front stage result: everything not needing the divider
    typedef struct packed {
        cmd_t  cmd;
        logic  differ;
        logic  div_zero;
        word_t quick;
        logic  cmp;
    } swa_ctl_t;

    typedef struct packed {
        swa_ctl_t ctl;
        word_t    ma;
        word_t    mb;
    } swa_front_t;

endpackage

@@ hw/rtl/swa_front.sv @@
// ----------------------------------------------------------------------------
// swa_front
// decode stage: magnitudes, simple ops, compares and product
// ----------------------------------------------------------------------------
module swa_front (
    input  logic                 aclk,
    input  logic                 adv,
    input  swa_pkg::cmd_t        cmd,
    input  swa_pkg::word_t       a,
    input  swa_pkg::word_t       b,
    input  swa_pkg::cnt_t        cnt,
    output swa_pkg::swa_front_t  q_reg
);
    import swa_pkg::*;

    swa_front_t q_next;
    word_t ma, mb, sh;
    logic  lt_ab, lt_ba;
    logic [2*WORD_BITS-1:0] prod;

    always_comb begin
        ma    = a[WORD_BITS-1] ? word_t'(-a) : a;
        mb    = b[WORD_BITS-1] ? word_t'(-b) : b;
        lt_ab = $signed(a) < $signed(b);
        lt_ba = $signed(b) < $signed(a);
        prod  = ma * mb;
        sh    = '0;
        q_next = '0;
        q_next.ctl.cmd    = cmd;
        q_next.ctl.differ = a[WORD_BITS-1] ^ b[WORD_BITS-1];
        q_next.ma = ma;
        q_next.mb = mb;
        case (cmd)
            CMD_ADD: q_next.ctl.quick = a + b;
            CMD_SUB: q_next.ctl.quick = a - b;
            CMD_MUL: q_next.ctl.quick = prod[WORD_BITS-1:0];
            CMD_DIV, CMD_REM: q_next.ctl.div_zero = (mb == '0);
            CMD_AND: q_next.ctl.quick = a & b;
            CMD_OR:  q_next.ctl.quick = a | b;
            CMD_XOR: q_next.ctl.quick = a ^ b;
            CMD_NOT: q_next.ctl.quick = ~a;
            CMD_SHL: begin
                sh = a << cnt;
                q_next.ctl.quick = (32'(cnt) >= WORD_BITS) ? '0 : sh;
            end
            CMD_SHR: begin
                sh = a >> cnt;
                q_next.ctl.quick = (32'(cnt) >= WORD_BITS) ? '0 : sh;
            end
            CMD_EQ:  q_next.ctl.cmp = (a == b);
            CMD_NE:  q_next.ctl.cmp = (a != b);
            CMD_LT:  q_next.ctl.cmp = lt_ab;
            CMD_LE:  q_next.ctl.cmp = !lt_ba;
            CMD_GT:  q_next.ctl.cmp = lt_ba;
            CMD_GE:  q_next.ctl.cmp = !lt_ab;
            default: q_next.ctl.quick = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            q_reg <= q_next;
        end
    end

endmodule

@@ hw/rtl/swa_div_stage.sv @@
// ----------------------------------------------------------------------------
// swa_div_stage
// DIV_STEPS restoring divide steps per register stage, one quotient bit per step
// ----------------------------------------------------------------------------
module swa_div_stage (
    input  logic            aclk,
    input  logic            adv,
    input  swa_pkg::swa_ctl_t ctl_in,
    input  swa_pkg::word_t  rem_in,
    input  swa_pkg::word_t  quo_in,
    input  swa_pkg::word_t  div_in,
    input  logic [4:0]      first_bit,
    output swa_pkg::swa_ctl_t ctl_reg,
    output swa_pkg::word_t  rem_reg,
    output swa_pkg::word_t  quo_reg,
    output swa_pkg::word_t  div_reg
);
    import swa_pkg::*;

    word_t rem_next, quo_next;
    logic [WORD_BITS:0] trial;
    int i;

    // quotient register starts as the dividend: dividend bits shift out msb first, quotient bits shift in at the lsb
    always_comb begin
        rem_next = rem_in;
        quo_next = quo_in;
        trial    = '0;
        for (i = 0; i < DIV_STEPS; i++) begin
            if (32'(first_bit) + i < WORD_BITS) begin
                trial = {rem_next, quo_next[WORD_BITS-1]};
                quo_next = quo_next << 1;
                if (trial >= {1'b0, div_in}) begin
                    trial = trial - {1'b0, div_in};
                    quo_next[0] = 1'b1;
                end
                rem_next = trial[WORD_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ctl_reg <= ctl_in;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            div_reg <= div_in;
        end
    end

endmodule

@@ hw/rtl/signed_word_alu.sv @@
// result path: an accepted input transaction passes through
// eight register stages (1 decode, 6 divide, 1 output)
// throughput: one transaction per cycle while the output is not stalled; the divider is unrolled into six stages
// of up to four restoring steps each, so no item waits on another
// a stall on the master side freezes every stage at once; nothing is lost
// reset: synchronous active-low aresetn clears the stage valid bits only
// ----------------------------------------------------------------------------
// signed_word_alu
// pipelined signed alu with add, sub, mul, div, rem, logic, shifts, compares
// ----------------------------------------------------------------------------
module signed_word_alu (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // tdata: cmd[4:0], operand_a[27:5], operand_b[50:28], shift_count[55:51]
    input  logic [8*swa_pkg::IN_BYTES-1:0]  s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // tdata: value[22:0]
    output logic [8*swa_pkg::OUT_BYTES-1:0] m_tdata,
    // tuser: compare_true[0], div_zero[1]
    output logic [1:0] m_tuser
);
    import swa_pkg::*;

    localparam int NSTAGE  = DIV_STAGES + 2;

    // one valid bit per stage; whole pipe advances when the output can move
    logic [NSTAGE-1:0] vld_reg;
    logic adv;

    assign adv      = !vld_reg[NSTAGE-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[NSTAGE-2:0], s_tvalid};
        end
    end

    // decode stage
    swa_front_t front;
    swa_front u_front (
        .aclk  (aclk),
        .adv   (adv),
        .cmd   (s_tdata[CMD_BITS-1:0]),
        .a     (s_tdata[CMD_BITS +: WORD_BITS]),
        .b     (s_tdata[CMD_BITS+WORD_BITS +: WORD_BITS]),
        .cnt   (s_tdata[CMD_BITS+2*WORD_BITS +: CNT_BITS]),
        .q_reg (front)
    );

    // divider chain
    swa_ctl_t ctl_c [DIV_STAGES+1];
    word_t    rem_c [DIV_STAGES+1];
    word_t    quo_c [DIV_STAGES+1];
    word_t    div_c [DIV_STAGES+1];

    assign ctl_c[0] = front.ctl;
    assign rem_c[0] = '0;
    assign quo_c[0] = front.ma;
    assign div_c[0] = front.mb;

    genvar g;
    generate
        for (g = 0; g < DIV_STAGES; g++) begin : g_div
            swa_div_stage u_stage (
                .aclk      (aclk),
                .adv       (adv),
                .ctl_in    (ctl_c[g]),
                .rem_in    (rem_c[g]),
                .quo_in    (quo_c[g]),
                .div_in    (div_c[g]),
                .first_bit (5'(DIV_STEPS * g)),
                .ctl_reg   (ctl_c[g+1]),
                .rem_reg   (rem_c[g+1]),
                .quo_reg   (quo_c[g+1]),
                .div_reg   (div_c[g+1])
            );
        end
    endgenerate

    // output stage: pick result, apply sign
    swa_ctl_t ctl_l;
    word_t    mag, val_next, val_reg;
    logic     cmp_reg, dz_reg;

    assign ctl_l = ctl_c[DIV_STAGES];

    always_comb begin
        mag      = (ctl_l.cmd == CMD_DIV) ? quo_c[DIV_STAGES] : rem_c[DIV_STAGES];
        val_next = ctl_l.quick;
        if (ctl_l.cmd == CMD_DIV || ctl_l.cmd == CMD_REM) begin
            if (ctl_l.div_zero) begin
                val_next = '0;
            end else begin
                val_next = ctl_l.differ ? word_t'(-mag) : mag;
            end
        end else if (ctl_l.cmd == CMD_MUL) begin
            val_next = ctl_l.differ ? word_t'(-ctl_l.quick) : ctl_l.quick;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            val_reg <= val_next;
            cmp_reg <= ctl_l.cmp;
            dz_reg  <= ctl_l.div_zero;
        end
    end

    assign m_tvalid = vld_reg[NSTAGE-1];
    assign m_tdata  = {{(8*OUT_BYTES-WORD_BITS){1'b0}}, val_reg};
    assign m_tuser  = {dz_reg, cmp_reg};

endmodule

@@ hw/rtl/swa_checker.sv @@
// ----------------------------------------------------------------------------
// swa_checker
// port-level checks for the signed word alu
// ----------------------------------------------------------------------------
module swa_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic [23:0] m_tdata,
    input logic [1:0]  m_tuser
);
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed under stall");

    // input side open whenever output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input blocked with empty output");

    // compare flag and divide error never together
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("compare and div_zero both set");

    // divide error gives zero value
    a_dz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata == '0)
        else $error("div_zero with nonzero value");

endmodule

bind signed_word_alu swa_checker u_swa_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
